[rtl/core/unicycle_waypoint_follower_unit_macros.svh]
// Assertion helpers for the waypoint follower checker.
`ifndef UNICYCLE_WAYPOINT_FOLLOWER_UNIT_MACROS_SVH
`define UNICYCLE_WAYPOINT_FOLLOWER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UWF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uwf checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off during reset.
`define UWF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uwf checker: next-cycle property failed");

`endif

[rtl/core/uwf_pkg.sv]
`timescale 1ns / 1ps
package uwf_pkg;

	localparam int MAX_WP = 64;
	localparam int WP_AW = $clog2(MAX_WP);

	localparam int CORDIC_STEPS = 16;
	localparam int CSTEP_W = $clog2(CORDIC_STEPS);
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// trig values, Q16.16, |v| <= 1.0 plus rounding
	localparam int CW = 18;
	// control point, Q16.16
	localparam int XW = 35;
	// position errors
	localparam int EW = 36;
	// proportional terms after rounding
	localparam int VW = 44;

	localparam int MA_W = 36;
	localparam int MB_W = 27;
	localparam int ACC_W = 64;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;

	typedef enum logic [CFG_IW-1:0] {
		CFG_OFFSET   = 3'd0,
		CFG_GAIN_X   = 3'd1,
		CFG_GAIN_Y   = 3'd2,
		CFG_REACH_SQ = 3'd3,
		CFG_MAX_LIN  = 3'd4,
		CFG_MAX_ROT  = 3'd5,
		CFG_WP_COUNT = 3'd6
	} cfg_reg_e;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} waypoint_t;

	// one issue slot of the shared multiply-accumulate unit
	typedef struct packed {
		logic                    valid;
		logic                    clr;
		logic                    sub;
		logic                    sh18;
		logic signed [MA_W-1:0]  a;
		logic signed [MB_W-1:0]  b;
	} mac_op_t;

	// arctan(2^-i) in units of 2^20 per turn
	function automatic logic [17:0] atan_units(input logic [CSTEP_W-1:0] i);
		logic [17:0] r;
		case (i)
			4'd0:    r = 18'd131072;
			4'd1:    r = 18'd77376;
			4'd2:    r = 18'd40884;
			4'd3:    r = 18'd20753;
			4'd4:    r = 18'd10417;
			4'd5:    r = 18'd5213;
			4'd6:    r = 18'd2607;
			4'd7:    r = 18'd1304;
			4'd8:    r = 18'd652;
			4'd9:    r = 18'd326;
			4'd10:   r = 18'd163;
			4'd11:   r = 18'd81;
			4'd12:   r = 18'd41;
			4'd13:   r = 18'd20;
			4'd14:   r = 18'd10;
			4'd15:   r = 18'd5;
			default: r = 18'd0;
		endcase
		return r;
	endfunction

	// round half up, then arithmetic shift
	function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] v,
		input int s);
		logic signed [ACC_W-1:0] half;
		half = 64'sd1 <<< (s - 1);
		return (v + half) >>> s;
	endfunction

endpackage

[rtl/core/uwf_cfg_if.sv]
`timescale 1ns / 1ps
interface uwf_cfg_if;
	import uwf_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/uwf_in_if.sv]
`timescale 1ns / 1ps
interface uwf_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [5:0]         waypoint_index;
	logic signed [31:0] waypoint_x;
	logic signed [31:0] waypoint_y;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic [15:0]        pose_heading;

	modport source (output valid, kind, waypoint_index, waypoint_x, waypoint_y, pose_x,
		pose_y, pose_heading, input ready);
	modport sink (input valid, kind, waypoint_index, waypoint_x, waypoint_y, pose_x,
		pose_y, pose_heading, output ready);
endinterface

[rtl/core/uwf_out_if.sv]
`timescale 1ns / 1ps
interface uwf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] linear_speed;
	logic signed [31:0] rotation_speed;
	logic [5:0]         target_index;
	logic               point_reached;
	logic               goal_reached;
	logic               linear_capped;
	logic               rotation_capped;

	modport source (output valid, linear_speed, rotation_speed, target_index, point_reached,
		goal_reached, linear_capped, rotation_capped, input ready);
	modport sink (input valid, linear_speed, rotation_speed, target_index, point_reached,
		goal_reached, linear_capped, rotation_capped, output ready);
endinterface

[rtl/core/uwf_ram.sv]
`timescale 1ns / 1ps
module uwf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/core/uwf_cordic.sv]
`timescale 1ns / 1ps
module uwf_cordic (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [15:0]                  heading,
	output logic                         done,
	output logic signed [uwf_pkg::CW-1:0] cos_q,
	output logic signed [uwf_pkg::CW-1:0] sin_q
);
	import uwf_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_ITER, C_ROUND} cst_t;

	cst_t                state_q;
	logic [CSTEP_W-1:0]  i_q;
	logic signed [33:0]  x_q, y_q;
	logic signed [20:0]  z_q;
	logic                flip_q;
	logic                done_q;

	logic [15:0]         t_rot;
	logic                flip_w;
	logic [15:0]         a_w;
	logic signed [20:0]  z0;
	logic signed [33:0]  xs, ys, nx, ny;
	logic signed [20:0]  nz, at;
	logic signed [33:0]  rx, ry;

	always_comb begin
		t_rot  = heading + 16'h4000;
		flip_w = t_rot[15];
		a_w    = flip_w ? (heading ^ 16'h8000) : heading;
		z0     = {a_w[15], a_w, 4'b0000};
		xs     = x_q >>> i_q;
		ys     = y_q >>> i_q;
		at     = 21'(atan_units(i_q));
		if (!z_q[20]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - at;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + at;
		end
		rx = (x_q + 34'sd8192) >>> 14;
		ry = (y_q + 34'sd8192) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == C_ROUND);
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q     <= CORDIC_GAIN;
						y_q     <= '0;
						z_q     <= z0;
						i_q     <= '0;
						flip_q  <= flip_w;
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					x_q <= nx;
					y_q <= ny;
					z_q <= nz;
					i_q <= i_q + 1'b1;
					if (i_q == CSTEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					cos_q   <= flip_q ? -rx[CW-1:0] : rx[CW-1:0];
					sin_q   <= flip_q ? -ry[CW-1:0] : ry[CW-1:0];
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
endmodule

[rtl/core/uwf_mac.sv]
`timescale 1ns / 1ps
module uwf_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  uwf_pkg::mac_op_t                  op,
	output logic signed [uwf_pkg::ACC_W-1:0]  acc
);
	import uwf_pkg::*;

	logic signed [MA_W+MB_W-1:0] p_s1;
	logic                        vld_s1, clr_s1, sub_s1, sh_s1;
	logic signed [ACC_W-1:0]     acc_q, base, term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= op.a * op.b;
		clr_s1 <= op.clr;
		sub_s1 <= op.sub;
		sh_s1  <= op.sh18;
	end

	always_comb begin
		base = clr_s1 ? '0 : acc_q;
		term = sh_s1 ? (ACC_W'(p_s1) <<< 18) : ACC_W'(p_s1);
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= sub_s1 ? (base - term) : (base + term);
		end
	end

	assign acc = acc_q;
endmodule

[rtl/core/unicycle_waypoint_follower_unit.sv]
`timescale 1ns / 1ps
// Waypoint write: one transfer; ready stays high, since the state stays idle.
// Pose sample: ready drops until the result is loaded, so no new item is taken while a pose
// is in work; the 16-step CORDIC and the single shared 36x27 multiply-accumulate unit pace it.
// The step that reaches the goal skips the velocity and speed steps; once finished, a pose
// goes from idle to done and returns a zero command. Reset (arst_n low, asynchronous):
// registers to defaults, target 0, not finished; the waypoint table is not cleared.
module unicycle_waypoint_follower_unit (
	input logic     clk,
	input logic     arst_n,
	uwf_cfg_if.sink cfg,
	uwf_in_if.sink  item,
	uwf_out_if.source result
);
	import uwf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_TRIG, S_PROJ, S_DIST, S_DECIDE, S_VEL, S_SPEED, S_ROT, S_DONE
	} state_t;

	// configuration registers
	logic [15:0] offset_q, gain_x_q, gain_y_q;
	logic [31:0] reach_sq_q;
	logic [30:0] max_lin_q, max_rot_q;
	logic [6:0]  wp_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= 16'd256;
			gain_x_q   <= 16'd256;
			gain_y_q   <= 16'd256;
			reach_sq_q <= 32'd65536;
			max_lin_q  <= 31'd65536;
			max_rot_q  <= 31'd65536;
			wp_count_q <= 7'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_OFFSET:   offset_q   <= cfg.data[15:0];
				CFG_GAIN_X:   gain_x_q   <= cfg.data[15:0];
				CFG_GAIN_Y:   gain_y_q   <= cfg.data[15:0];
				CFG_REACH_SQ: reach_sq_q <= cfg.data;
				CFG_MAX_LIN:  max_lin_q  <= cfg.data[30:0];
				CFG_MAX_ROT:  max_rot_q  <= cfg.data[30:0];
				CFG_WP_COUNT: wp_count_q <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t           state_q;
	logic [3:0]       sub_q;
	logic [1:0]       rdph_q;
	logic [WP_AW-1:0] cur_q;
	logic             finished_q;

	// per-pose working registers
	logic signed [31:0]   px_q, py_q;
	logic signed [XW-1:0] xp_q, yp_q;
	waypoint_t            wl_q, we_q, wn_q, wsel_q;
	logic [31:0]          sq_q [4];
	logic signed [VW-1:0] v1_q, v2_q, r_q;
	logic signed [ACC_W-1:0] lin_q, rot_q;
	logic                 zero_q, goal_q, pr_q;

	// result register
	logic               res_valid_q;
	logic signed [31:0] res_lin_q, res_rot_q;
	logic [5:0]         res_tgt_q;
	logic               res_pr_q, res_goal_q, res_lcap_q, res_rcap_q;

	wire acc_in   = item.valid && item.ready;
	wire wr_in    = acc_in && !item.kind;
	wire pose_in  = acc_in && item.kind;
	wire res_free = !res_valid_q || result.ready;

	// last waypoint and saturated current target
	logic [31:0]      cnt32, cnt_sat;
	logic [WP_AW-1:0] last_w, eff_w, eff_nx;
	logic             can_adv;

	always_comb begin
		cnt32 = 32'(wp_count_q);
		if (cnt32 == 32'd0) begin
			cnt_sat = 32'd1;
		end else if (cnt32 > 32'(MAX_WP)) begin
			cnt_sat = 32'(MAX_WP);
		end else begin
			cnt_sat = cnt32;
		end
		last_w  = WP_AW'(cnt_sat - 32'd1);
		eff_w   = (cur_q > last_w) ? last_w : cur_q;
		can_adv = eff_w < last_w;
		eff_nx  = can_adv ? (eff_w + 1'b1) : eff_w;
	end

	// waypoint table
	logic             ram_re;
	logic [WP_AW-1:0] ram_raddr;
	waypoint_t        ram_rdata, wp_wdata;

	assign wp_wdata = '{x: item.waypoint_x, y: item.waypoint_y};

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = last_w;
		if (pose_in) begin
			ram_re    = 1'b1;
			ram_raddr = last_w;
		end else if (state_q == S_TRIG && rdph_q == 2'd0) begin
			ram_re    = 1'b1;
			ram_raddr = eff_w;
		end else if (state_q == S_TRIG && rdph_q == 2'd1) begin
			ram_re    = 1'b1;
			ram_raddr = eff_nx;
		end
	end

	uwf_ram #(.WIDTH($bits(waypoint_t)), .DEPTH(MAX_WP)) u_store (
		.clk   (clk),
		.we    (wr_in && (32'(item.waypoint_index) < 32'(MAX_WP))),
		.waddr (WP_AW'(item.waypoint_index)),
		.wdata (wp_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// heading to cos/sin
	logic                 trig_done;
	logic signed [CW-1:0] cos_w, sin_w;

	uwf_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pose_in && !finished_q),
		.heading (item.pose_heading),
		.done    (trig_done),
		.cos_q   (cos_w),
		.sin_q   (sin_w)
	);

	// errors of the control point to last, current and chosen waypoints
	logic signed [EW-1:0] e_lx, e_ly, e_ex, e_ey, e_x, e_y, e_sel;
	logic [23:0]          ax_sel;
	logic                 in_l, in_e;

	function automatic logic in_reach_box(input logic signed [EW-1:0] e);
		return (e > -(EW'(1) <<< 24)) && (e < (EW'(1) <<< 24));
	endfunction

	always_comb begin
		e_lx = EW'(xp_q) - EW'(wl_q.x);
		e_ly = EW'(yp_q) - EW'(wl_q.y);
		e_ex = EW'(xp_q) - EW'(we_q.x);
		e_ey = EW'(yp_q) - EW'(we_q.y);
		e_x  = EW'(xp_q) - EW'(wsel_q.x);
		e_y  = EW'(yp_q) - EW'(wsel_q.y);
		in_l = in_reach_box(e_lx) && in_reach_box(e_ly);
		in_e = in_reach_box(e_ex) && in_reach_box(e_ey);
		case (sub_q[1:0])
			2'd0:    e_sel = e_lx;
			2'd1:    e_sel = e_ly;
			2'd2:    e_sel = e_ex;
			default: e_sel = e_ey;
		endcase
		ax_sel = e_sel[EW-1] ? 24'(-e_sel) : e_sel[23:0];
	end

	// shared multiply-accumulate issue
	mac_op_t                 op;
	logic signed [ACC_W-1:0] acc;
	logic signed [MA_W-1:0]  l1_a, v1h, v1l, v2h, v2l, rh, rl;
	logic signed [MB_W-1:0]  c_b, s_b, off_b;

	always_comb begin
		l1_a  = MA_W'({offset_q, 8'h00});
		c_b   = MB_W'(cos_w);
		s_b   = MB_W'(sin_w);
		off_b = MB_W'(offset_q);
		v1h   = MA_W'($signed(v1_q[VW-1:18]));
		v1l   = MA_W'(v1_q[17:0]);
		v2h   = MA_W'($signed(v2_q[VW-1:18]));
		v2l   = MA_W'(v2_q[17:0]);
		rh    = MA_W'($signed(r_q[VW-1:18]));
		rl    = MA_W'(r_q[17:0]);

		op = '{valid: 1'b0, clr: 1'b0, sub: 1'b0, sh18: 1'b0, a: '0, b: '0};
		case (state_q)
			S_PROJ: begin
				op.clr = 1'b1;
				op.a   = l1_a;
				op.b   = sub_q[0] ? s_b : c_b;
				op.valid = sub_q < 4'd2;
			end
			S_DIST: begin
				op.clr   = 1'b1;
				op.a     = MA_W'(ax_sel);
				op.b     = MB_W'(ax_sel);
				op.valid = sub_q < 4'd4;
			end
			S_VEL: begin
				op.clr   = 1'b1;
				op.sub   = 1'b1;
				op.a     = sub_q[0] ? e_y : e_x;
				op.b     = sub_q[0] ? MB_W'(gain_y_q) : MB_W'(gain_x_q);
				op.valid = sub_q < 4'd2;
			end
			S_SPEED: begin
				// linear: c*v1 + s*v2, then rotation: c*v2 - s*v1
				op.valid = sub_q < 4'd8;
				case (sub_q[2:0])
					3'd0: begin op.a = v1h; op.b = c_b; op.clr = 1'b1; op.sh18 = 1'b1; end
					3'd1: begin op.a = v1l; op.b = c_b; end
					3'd2: begin op.a = v2h; op.b = s_b; op.sh18 = 1'b1; end
					3'd3: begin op.a = v2l; op.b = s_b; end
					3'd4: begin op.a = v2h; op.b = c_b; op.clr = 1'b1; op.sh18 = 1'b1; end
					3'd5: begin op.a = v2l; op.b = c_b; end
					3'd6: begin op.a = v1h; op.b = s_b; op.sub = 1'b1; op.sh18 = 1'b1; end
					default: begin op.a = v1l; op.b = s_b; op.sub = 1'b1; end
				endcase
			end
			S_ROT: begin
				op.a     = sub_q[0] ? rl : rh;
				op.b     = off_b;
				op.clr   = !sub_q[0];
				op.sh18  = !sub_q[0];
				op.valid = sub_q < 4'd2;
			end
			default: ;
		endcase
	end

	uwf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc)
	);

	// reach decisions and clamping
	logic [32:0]             d_l, d_e;
	logic                    goal_w, cur_w;
	logic signed [ACC_W-1:0] lim_l, lim_r, lin_c, rot_c;
	logic                    lcap, rcap;

	always_comb begin
		d_l    = 33'(sq_q[0]) + 33'(sq_q[1]);
		d_e    = 33'(sq_q[2]) + 33'(sq_q[3]);
		goal_w = in_l && (d_l < 33'(reach_sq_q));
		cur_w  = in_e && (d_e < 33'(reach_sq_q));

		lim_l = ACC_W'(max_lin_q);
		lim_r = ACC_W'(max_rot_q);
		lcap  = 1'b1;
		rcap  = 1'b1;
		if (lin_q > lim_l) begin
			lin_c = lim_l;
		end else if (lin_q < -lim_l) begin
			lin_c = -lim_l;
		end else begin
			lin_c = lin_q;
			lcap  = 1'b0;
		end
		if (rot_q > lim_r) begin
			rot_c = lim_r;
		end else if (rot_q < -lim_r) begin
			rot_c = -lim_r;
		end else begin
			rot_c = rot_q;
			rcap  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sub_q       <= '0;
			rdph_q      <= '0;
			cur_q       <= '0;
			finished_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// result register loads from S_DONE, clears on transfer
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					sub_q  <= '0;
					rdph_q <= '0;
					if (pose_in) begin
						px_q <= item.pose_x;
						py_q <= item.pose_y;
						if (finished_q) begin
							zero_q  <= 1'b1;
							goal_q  <= 1'b1;
							pr_q    <= 1'b0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_TRIG;
						end
					end
				end
				S_TRIG: begin
					// table reads run under the CORDIC iterations
					if (rdph_q != 2'd3) begin
						rdph_q <= rdph_q + 1'b1;
					end
					case (rdph_q)
						2'd0:    wl_q <= ram_rdata;
						2'd1:    we_q <= ram_rdata;
						2'd2:    wn_q <= ram_rdata;
						default: ;
					endcase
					if (trig_done) begin
						sub_q   <= '0;
						state_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					if (sub_q == 4'd2) begin
						xp_q <= XW'(px_q) + XW'(rnd_sh(acc, 16));
					end
					if (sub_q == 4'd3) begin
						yp_q    <= XW'(py_q) + XW'(rnd_sh(acc, 16));
						sub_q   <= '0;
						state_q <= S_DIST;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				S_DIST: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q >= 4'd2) begin
						sq_q[2'(sub_q - 4'd2)] <= acc[47:16];
					end
					if (sub_q == 4'd5) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					sub_q <= '0;
					pr_q  <= cur_w;
					if (goal_w) begin
						finished_q <= 1'b1;
						cur_q      <= eff_w;
						zero_q     <= 1'b1;
						goal_q     <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						cur_q   <= (cur_w && can_adv) ? eff_nx : eff_w;
						wsel_q  <= (cur_w && can_adv) ? wn_q : we_q;
						zero_q  <= 1'b0;
						goal_q  <= 1'b0;
						state_q <= S_VEL;
					end
				end
				S_VEL: begin
					if (sub_q == 4'd2) begin
						v1_q <= VW'(rnd_sh(acc, 8));
					end
					if (sub_q == 4'd3) begin
						v2_q    <= VW'(rnd_sh(acc, 8));
						sub_q   <= '0;
						state_q <= S_SPEED;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				S_SPEED: begin
					if (sub_q == 4'd5) begin
						lin_q <= rnd_sh(acc, 16);
					end
					if (sub_q == 4'd9) begin
						r_q     <= VW'(rnd_sh(acc, 16));
						sub_q   <= '0;
						state_q <= S_ROT;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				S_ROT: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 4'd3) begin
						rot_q   <= rnd_sh(acc, 8);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						res_lin_q   <= zero_q ? '0 : lin_c[31:0];
						res_rot_q   <= zero_q ? '0 : rot_c[31:0];
						res_tgt_q   <= 6'(cur_q);
						res_pr_q    <= pr_q;
						res_goal_q  <= goal_q;
						res_lcap_q  <= !zero_q && lcap;
						res_rcap_q  <= !zero_q && rcap;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready             = (state_q == S_IDLE);
	assign result.valid           = res_valid_q;
	assign result.linear_speed    = res_lin_q;
	assign result.rotation_speed  = res_rot_q;
	assign result.target_index    = res_tgt_q;
	assign result.point_reached   = res_pr_q;
	assign result.goal_reached    = res_goal_q;
	assign result.linear_capped   = res_lcap_q;
	assign result.rotation_capped = res_rcap_q;
endmodule

[rtl/core/uwf_checker.sv]
`timescale 1ns / 1ps
`include "unicycle_waypoint_follower_unit_macros.svh"
module uwf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_kind,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] lin,
	input logic [31:0] rot,
	input logic        goal,
	input logic        lcap,
	input logic        rcap
);
	// pending result holds until transfer
	`UWF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(lin) && $stable(rot))
	// goal gives a zero command
	`UWF_ASSERT_NOW(a_goal_zero, res_valid && goal, lin == 32'd0 && rot == 32'd0)
	// goal command is never flagged as clamped
	`UWF_ASSERT_NOW(a_goal_nocap, res_valid && goal, !lcap && !rcap)
	// a pose transfer leaves the block busy in the cycle after it
	`UWF_ASSERT_NEXT(a_pose_busy, item_valid && item_ready && item_kind, !item_ready)
endmodule

bind unicycle_waypoint_follower_unit uwf_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_kind  (item.kind),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.lin        (result.linear_speed),
	.rot        (result.rotation_speed),
	.goal       (result.goal_reached),
	.lcap       (result.linear_capped),
	.rcap       (result.rotation_capped)
);

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
	import uwf_pkg::*;

	// one input transfer as the predictor sees it
	typedef struct {
		bit                 kind;
		logic [5:0]         slot;
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        hd;
	} sample_t;

	// one command transfer on the result channel
	typedef struct {
		logic signed [31:0] lin;
		logic signed [31:0] rot;
		logic [5:0]         tgt;
		bit                 pnt;
		bit                 goal;
		bit                 lcap;
		bit                 rcap;
	} command_t;

	// directed row; with aim set, a and b are noise added to a pose that puts the
	// control point right on the current target
	typedef struct {
		bit                 kind;
		bit                 aim;
		logic [5:0]         slot;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic [15:0]        hd;
	} row_t;

	localparam int SLOTS = 64;
	localparam int SETTLE = 60;
	localparam longint ATAN_TAB [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
		1304, 652, 326, 163, 81, 41, 20, 10, 5};
	localparam longint CORDIC_START = 652032874;
	localparam logic signed [31:0] FAR = 32'sh4000_0000;

	logic clk;
	logic arst_n;

	uwf_cfg_if cfg_ch ();
	uwf_in_if  in_ch ();
	uwf_out_if out_ch ();

	unicycle_waypoint_follower_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (in_ch),
		.result (out_ch)
	);

	// follower state mirrored in the testbench
	logic [15:0] m_offset, m_gain_x, m_gain_y;
	logic [31:0] m_reach;
	logic [30:0] m_max_lin, m_max_rot;
	logic [6:0]  m_count;
	longint      wp_x [SLOTS];
	longint      wp_y [SLOTS];
	int          m_target;
	bit          m_done;

	command_t cmd_q [$];
	int       errors;
	int       idle_pct, stall_pct;
	int       n_pose, n_write, n_reached, n_capped, n_cmd;
	int       far_slot;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- arithmetic
	function automatic longint round_sh(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// cos/sin of a binary angle, Q16.16, by the same 16-step rotation the block uses
	function automatic void heading_trig(input logic [15:0] hd, output longint c,
		output longint s);
		logic [15:0] a;
		bit          flip;
		longint      x, y, z, nx;
		a = hd;
		flip = (16'(a + 16'h4000) >= 16'h8000);
		if (flip)
			a = a ^ 16'h8000;
		z = longint'($signed(a)) * 16;
		x = CORDIC_START;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_TAB[i];
			end
			x = nx;
		end
		c = round_sh(x, 14);
		s = round_sh(y, 14);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	// squared-distance reach test; errors of 2^24 or more never count
	function automatic bit within_reach(input longint ex, input longint ey);
		longint ax, ay, d2;
		if (ex <= -(64'sd1 <<< 24) || ex >= (64'sd1 <<< 24) ||
			ey <= -(64'sd1 <<< 24) || ey >= (64'sd1 <<< 24))
			return 1'b0;
		ax = (ex < 0) ? -ex : ex;
		ay = (ey < 0) ? -ey : ey;
		d2 = ((ax * ax) >>> 16) + ((ay * ay) >>> 16);
		return d2 < longint'({32'b0, m_reach});
	endfunction

	function automatic longint limit_speed(input longint v, input logic [30:0] lim,
		output bit capped);
		longint m;
		m = longint'({33'b0, lim});
		capped = 1'b0;
		if (v > m) begin
			capped = 1'b1;
			return m;
		end
		if (v < -m) begin
			capped = 1'b1;
			return -m;
		end
		return v;
	endfunction

	function automatic int last_slot();
		int n;
		n = m_count;
		if (n < 1)
			n = 1;
		if (n > SLOTS)
			n = SLOTS;
		return n - 1;
	endfunction

	function automatic int active_target();
		return (m_target > last_slot()) ? last_slot() : m_target;
	endfunction

	// pose that places the control point on the current target, plus noise
	function automatic void aim_pose(input logic [15:0] hd, input longint nx,
		input longint ny, output logic signed [31:0] px, output logic signed [31:0] py);
		longint c, s, l1;
		int     t;
		t = active_target();
		heading_trig(hd, c, s);
		l1 = longint'({48'b0, m_offset}) <<< 8;
		px = 32'(wp_x[t] - round_sh(l1 * c, 16) + nx);
		py = 32'(wp_y[t] - round_sh(l1 * s, 16) + ny);
	endfunction

	// applies one accepted transfer to the mirrored state; returns 1 with the
	// command it should produce when the transfer is a pose
	function automatic bit follow_step(input sample_t it, output command_t r);
		longint c, s, xp, yp, l1, ex, ey, v1, v2, lin, rot;
		int     last, eff;
		bit     goal, cur, lc, rc;
		r = '{default: 0};
		if (!it.kind) begin
			wp_x[it.slot] = longint'(it.wx);
			wp_y[it.slot] = longint'(it.wy);
			return 1'b0;
		end
		r.goal = 1'b1;
		if (m_done) begin
			r.tgt = 6'(m_target);
			return 1'b1;
		end
		last = last_slot();
		eff = active_target();
		heading_trig(it.hd, c, s);
		l1 = longint'({48'b0, m_offset}) <<< 8;
		xp = longint'(it.px) + round_sh(l1 * c, 16);
		yp = longint'(it.py) + round_sh(l1 * s, 16);
		goal = within_reach(xp - wp_x[last], yp - wp_y[last]);
		cur = within_reach(xp - wp_x[eff], yp - wp_y[eff]);
		if (goal) begin
			m_done = 1'b1;
			m_target = eff;
			r.tgt = 6'(eff);
			r.pnt = cur;
			return 1'b1;
		end
		if (cur && eff < last)
			eff++;
		m_target = eff;
		ex = xp - wp_x[eff];
		ey = yp - wp_y[eff];
		v1 = round_sh(-(longint'({48'b0, m_gain_x}) * ex), 8);
		v2 = round_sh(-(longint'({48'b0, m_gain_y}) * ey), 8);
		lin = round_sh(c * v1 + s * v2, 16);
		rot = round_sh(round_sh(c * v2 - s * v1, 16) * longint'({48'b0, m_offset}), 8);
		lin = limit_speed(lin, m_max_lin, lc);
		rot = limit_speed(rot, m_max_rot, rc);
		r.lin = 32'(lin);
		r.rot = 32'(rot);
		r.tgt = 6'(eff);
		r.pnt = cur;
		r.goal = 1'b0;
		r.lcap = lc;
		r.rcap = rc;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- drivers
	// Inputs change on the falling edge; a transfer is the rising edge with
	// valid and ready both high. When force_cmd is set the typed command
	// replaces the predicted one (the predictor still advances).
	task automatic send_sample(input sample_t it, input bit force_cmd, input command_t typed);
		command_t exp_cmd;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.kind = it.kind;
		in_ch.waypoint_index = it.slot;
		in_ch.waypoint_x = it.wx;
		in_ch.waypoint_y = it.wy;
		in_ch.pose_x = it.px;
		in_ch.pose_y = it.py;
		in_ch.pose_heading = it.hd;
		do
			@(posedge clk);
		while (!in_ch.ready);
		if (follow_step(it, exp_cmd)) begin
			cmd_q = {cmd_q, force_cmd ? typed : exp_cmd};
			n_pose++;
			n_reached += exp_cmd.pnt;
			n_capped += exp_cmd.lcap | exp_cmd.rcap;
		end else
			n_write++;
	endtask

	task automatic write_slot(input int slot, input logic signed [31:0] x,
		input logic signed [31:0] y);
		sample_t it;
		it = '{kind: 1'b0, slot: 6'(slot), wx: x, wy: y, px: $urandom, py: $urandom,
			hd: 16'($urandom)};
		send_sample(it, 1'b0, '{default: 0});
	endtask

	task automatic send_pose(input logic signed [31:0] px, input logic signed [31:0] py,
		input logic [15:0] hd);
		sample_t it;
		it = '{kind: 1'b1, slot: 6'($urandom), wx: $urandom, wy: $urandom, px: px, py: py,
			hd: hd};
		send_sample(it, 1'b0, '{default: 0});
	endtask

	task automatic reg_write(input cfg_reg_e idx, input logic [31:0] v);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		case (idx)
			CFG_OFFSET:   m_offset = v[15:0];
			CFG_GAIN_X:   m_gain_x = v[15:0];
			CFG_GAIN_Y:   m_gain_y = v[15:0];
			CFG_REACH_SQ: m_reach = v;
			CFG_MAX_LIN:  m_max_lin = v[30:0];
			CFG_MAX_ROT:  m_max_rot = v[30:0];
			CFG_WP_COUNT: m_count = v[6:0];
			default: ;
		endcase
	endtask

	// registers change only with nothing in flight; a write transfer has no
	// result, so allow the block its pose latency on top
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (cmd_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] off, input logic [31:0] gx,
		input logic [31:0] gy, input logic [31:0] reach, input logic [31:0] mlin,
		input logic [31:0] mrot, input logic [31:0] cnt);
		drain();
		reg_write(CFG_OFFSET, off);
		reg_write(CFG_GAIN_X, gx);
		reg_write(CFG_GAIN_Y, gy);
		reg_write(CFG_REACH_SQ, reach);
		reg_write(CFG_MAX_LIN, mlin);
		reg_write(CFG_MAX_ROT, mrot);
		reg_write(CFG_WP_COUNT, cnt);
	endtask

	// noise for an aimed pose: zero, a small, medium or large spread, or at the large-error cutoff
	function automatic longint pick_noise();
		longint r;
		case ($urandom_range(4))
			0: return 0;
			1: r = 'h100;
			2: r = 'hC000;
			3: r = 'h60000;
			default: return $urandom_range(1) ? ((64'sd1 <<< 24) - $urandom_range(1))
				: -((64'sd1 <<< 24) - $urandom_range(1));
		endcase
		return longint'($urandom_range(2 * r)) - r;
	endfunction

	task automatic near_waypoint(input int slot);
		write_slot(slot, 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000),
			32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000));
	endtask

	task automatic run_setting(input int items);
		logic signed [31:0] px, py;
		logic [15:0]        hd;
		int                 last, s;
		last = last_slot();
		if (far_slot != last) begin
			near_waypoint(far_slot);
			write_slot(last, FAR + 32'($urandom_range(16'hFFFF)),
				-FAR - 32'($urandom_range(16'hFFFF)));
			far_slot = last;
		end
		repeat (items) begin
			if ($urandom_range(99) < 15) begin
				s = $urandom_range(SLOTS - 1);
				if (s == last)
					s = (s + 1) % SLOTS;
				if ($urandom_range(7) == 0)
					write_slot(s, $urandom, $urandom);
				else
					near_waypoint(s);
			end else begin
				hd = 16'($urandom);
				// aiming at the last slot would finish the run early
				if ($urandom_range(99) < 60 && active_target() != last) begin
					aim_pose(hd, pick_noise(), pick_noise(), px, py);
					send_pose(px, py, hd);
				end else
					send_pose($urandom, $urandom, hd);
			end
		end
	endtask

	// ---------------------------------------------------------------- result side
	always @(negedge clk)
		out_ch.ready = ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		command_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_cmd++;
			if (cmd_q.size() == 0) begin
				$error("command with nothing expected");
				errors++;
			end else begin
				e = cmd_q.pop_front();
				if (out_ch.linear_speed !== e.lin) begin
					$error("linear_speed exp %0d got %0d", e.lin, out_ch.linear_speed);
					errors++;
				end
				if (out_ch.rotation_speed !== e.rot) begin
					$error("rotation_speed exp %0d got %0d", e.rot, out_ch.rotation_speed);
					errors++;
				end
				if (out_ch.target_index !== e.tgt) begin
					$error("target_index exp %0d got %0d", e.tgt, out_ch.target_index);
					errors++;
				end
				if (out_ch.point_reached !== e.pnt) begin
					$error("point_reached exp %0b got %0b", e.pnt, out_ch.point_reached);
					errors++;
				end
				if (out_ch.goal_reached !== e.goal) begin
					$error("goal_reached exp %0b got %0b", e.goal, out_ch.goal_reached);
					errors++;
				end
				if (out_ch.linear_capped !== e.lcap) begin
					$error("linear_capped exp %0b got %0b", e.lcap, out_ch.linear_capped);
					errors++;
				end
				if (out_ch.rotation_capped !== e.rcap) begin
					$error("rotation_capped exp %0b got %0b", e.rcap, out_ch.rotation_capped);
					errors++;
				end
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#5ms;
		$display("** unicycle_waypoint_follower_unit: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence
	row_t steer_rows [] = '{
		'{1'b0, 1'b0, 6'd62, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0000},
		'{1'b0, 1'b0, 6'd61, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'h0000},
		'{1'b1, 1'b0, 6'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0000},
		'{1'b1, 1'b0, 6'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF},
		'{1'b1, 1'b0, 6'd0, 32'sh0, 32'sh0, 16'h4000},
		'{1'b1, 1'b0, 6'd0, 32'sh0, 32'sh0, 16'h8000},
		'{1'b1, 1'b0, 6'd0, 32'sh0, 32'sh0, 16'hC000},
		'{1'b1, 1'b0, 6'd0, 32'sh0, 32'sh0, 16'h2000},
		'{1'b1, 1'b0, 6'd0, 32'sh0, 32'sh0, 16'h6000},
		'{1'b1, 1'b0, 6'd0, 32'sh0, 32'sh0, 16'hA000},
		// control point dead on the target, then around the reach boundary
		'{1'b1, 1'b1, 6'd0, 32'sh0, 32'sh0, 16'h0000},
		'{1'b1, 1'b1, 6'd0, 32'sh100, -32'sh100, 16'h1234},
		'{1'b1, 1'b1, 6'd0, 32'sh10000, 32'sh0, 16'h7FFF},
		'{1'b1, 1'b1, 6'd0, 32'shFFFF, 32'sh0, 16'h8001},
		// error components at the large-error cutoff
		'{1'b1, 1'b1, 6'd0, 32'sh100_0000, 32'sh0, 16'h3FFF},
		'{1'b1, 1'b1, 6'd0, -32'sh100_0000, 32'sh5, 16'hC001},
		'{1'b0, 1'b0, 6'd63, 32'sh4000_1234, 32'sh7FFF_0000, 16'h0000},
		'{1'b1, 1'b0, 6'd0, 32'sh1234_5678, 32'shEDCB_A987, 16'h5A5A},
		'{1'b1, 1'b1, 6'd0, 32'sh0, 32'sh0, 16'hA5A5}
	};

	initial begin
		logic signed [31:0] px, py;
		command_t           typed;
		int                 tries;
		errors = 0;
		n_pose = 0;
		n_write = 0;
		n_reached = 0;
		n_capped = 0;
		n_cmd = 0;
		idle_pct = 14;
		stall_pct = 83;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_OFFSET;
		cfg_ch.data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = 1'b0;
		in_ch.waypoint_index = '0;
		in_ch.waypoint_x = '0;
		in_ch.waypoint_y = '0;
		in_ch.pose_x = '0;
		in_ch.pose_y = '0;
		in_ch.pose_heading = '0;
		out_ch.ready = 1'b0;
		// reset values
		m_offset = 16'd256;
		m_gain_x = 16'd256;
		m_gain_y = 16'd256;
		m_reach = 32'd65536;
		m_max_lin = 31'd65536;
		m_max_rot = 31'd65536;
		m_count = 7'd1;
		m_target = 0;
		m_done = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			wp_x[i] = 0;
			wp_y[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole table before any pose reads it; slot 63 stays far
		for (int i = 0; i < SLOTS - 1; i++)
			near_waypoint(i);
		write_slot(SLOTS - 1, FAR, FAR);
		far_slot = SLOTS - 1;
		drain();
		reg_write(CFG_WP_COUNT, 32'd64);

		// directed rows at reset gains and limits
		foreach (steer_rows[i]) begin
			if (!steer_rows[i].kind)
				write_slot(steer_rows[i].slot, steer_rows[i].a, steer_rows[i].b);
			else if (steer_rows[i].aim) begin
				aim_pose(steer_rows[i].hd, longint'(steer_rows[i].a),
					longint'(steer_rows[i].b), px, py);
				send_pose(px, py, steer_rows[i].hd);
			end else
				send_pose(steer_rows[i].a, steer_rows[i].b, steer_rows[i].hd);
		end

		// random traffic over a sweep of settings, extremes included
		program_regs(256, 256, 256, 65536, 65536, 65536, 8);
		run_setting(55);
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 64);
		run_setting(55);
		idle_pct = 83;
		stall_pct = 14;
		// zero limits and a count of zero (acts as one)
		program_regs(0, 0, 0, 0, 0, 0, 0);
		run_setting(55);
		// count above the table size saturates
		program_regs(128, 1000, 40, 200000, 32'h7FFF_FFFF, 0, 100);
		run_setting(55);
		idle_pct = 0;
		stall_pct = 0;
		program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom_range(1, 64));
		run_setting(55);
		// shrinking the count pulls a target beyond the end back to the last slot
		program_regs(512, 300, 300, 32'h0010_0000, 32'h0004_0000, 32'h0004_0000, 3);
		run_setting(55);

		// drive onto the final waypoint, then confirm the stop is sticky
		program_regs(256, 256, 256, 65536, 65536, 65536, 5);
		near_waypoint(far_slot);
		write_slot(4, 32'sh0003_0000, -32'sh0002_0000);
		far_slot = 4;
		tries = 0;
		while (!m_done && tries < 40) begin
			aim_pose(16'h1C00, longint'($urandom_range(32)) - 16, 0, px, py);
			send_pose(px, py, 16'h1C00);
			tries++;
		end
		repeat (6) begin
			typed = '{lin: 0, rot: 0, tgt: 6'(m_target), pnt: 0, goal: 1, lcap: 0, rcap: 0};
			if ($urandom_range(2) == 0)
				write_slot($urandom_range(SLOTS - 1), $urandom, $urandom);
			aim_pose(16'h0000, 0, 0, px, py);
			send_sample('{kind: 1'b1, slot: 6'd0, wx: 0, wy: 0, px: px, py: py,
				hd: 16'h0000}, 1'b1, typed);
		end
		@(negedge clk);
		in_ch.valid = 1'b0;

		drain();
		$display("run covered %0d pose and %0d waypoint transfers, %0d commands seen",
			n_pose, n_write, n_cmd);
		$display("  %0d waypoint hits, %0d capped commands, goal reached %0b",
			n_reached, n_capped, m_done);
		if (errors == 0)
			$display("** unicycle_waypoint_follower_unit: PASSED **");
		else
			$display("** unicycle_waypoint_follower_unit: FAILED **");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/uwf_pkg.sv
rtl/core/uwf_cfg_if.sv
rtl/core/uwf_in_if.sv
rtl/core/uwf_out_if.sv
rtl/core/uwf_ram.sv
rtl/core/uwf_cordic.sv
rtl/core/uwf_mac.sv
rtl/core/unicycle_waypoint_follower_unit.sv
rtl/core/uwf_checker.sv
dv/tb.sv
